/* rtl/sbp_pkg.sv */
package sbp_pkg;

  localparam int PAGE_BYTES_DEF = 256;
  localparam int MAX_RES = 7;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ADDR_HI, PH_ADDR_LO, PH_BSZ_HI, PH_BSZ_LO, PH_BTYPE, PH_BDATA,
    PH_GSZ_HI, PH_GSZ_LO, PH_GTYPE, PH_WAIT_FLASH, PH_WAIT_EE, PH_WAIT_FUSE,
    PH_SKIP_ARG, PH_DEV_ARG
  } phase_t;

  typedef enum logic [1:0] {
    SP_NONE, SP_FLASH, SP_EE, SP_BADDEV
  } space_t;

  typedef enum logic [3:0] {
    K_REPLY = 4'd0, K_FILL = 4'd1, K_COMMIT = 4'd2, K_EEWR = 4'd3, K_FLRD = 4'd4,
    K_EERD = 4'd5, K_FUSE = 4'd6, K_ERASE = 4'd7, K_RESET = 4'd8
  } kind_t;

  localparam logic [2:0] REG_DEVICE = 3'd0;
  localparam logic [2:0] REG_APP_END = 3'd1;
  localparam logic [2:0] REG_PROTECT = 3'd2;
  localparam logic [2:0] REG_SIG1 = 3'd3;
  localparam logic [2:0] REG_SIG2 = 3'd4;
  localparam logic [2:0] REG_SIG3 = 3'd5;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_ESC = 8'h1b;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  reply_byte;
    logic [15:0] mem_address;
    logic [15:0] mem_data;
    logic [1:0]  fuse_select;
  } res_t;

  typedef struct packed {
    logic [7:0]  device_code;
    logic [17:0] app_end_bytes;
    logic        read_protect;
    logic [7:0]  sig_first;
    logic [7:0]  sig_second;
    logic [7:0]  sig_third;
  } cfg_t;

  function automatic res_t mk(logic [3:0] k, logic [7:0] rb, logic [15:0] a,
                              logic [15:0] d, logic [1:0] f);
    res_t r;
    r.kind = k;
    r.reply_byte = rb;
    r.mem_address = a;
    r.mem_data = d;
    r.fuse_select = f;
    return r;
  endfunction

endpackage

/* rtl/sbp_regs.sv */
module sbp_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sbp_pkg::cfg_t     cfg
);
  import sbp_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_code <= 8'd68;
      cfg.app_end_bytes <= 18'd122880;
      cfg.read_protect <= 1'b1;
      cfg.sig_first <= 8'd30;
      cfg.sig_second <= 8'd167;
      cfg.sig_third <= 8'd1;
    end else if (wr) begin
      case (idx)
        REG_DEVICE: cfg.device_code <= pwdata[7:0];
        REG_APP_END: cfg.app_end_bytes <= pwdata[17:0];
        REG_PROTECT: cfg.read_protect <= pwdata[0];
        REG_SIG1: cfg.sig_first <= pwdata[7:0];
        REG_SIG2: cfg.sig_second <= pwdata[7:0];
        REG_SIG3: cfg.sig_third <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEVICE: prdata = {24'd0, cfg.device_code};
      REG_APP_END: prdata = {14'd0, cfg.app_end_bytes};
      REG_PROTECT: prdata = {31'd0, cfg.read_protect};
      REG_SIG1: prdata = {24'd0, cfg.sig_first};
      REG_SIG2: prdata = {24'd0, cfg.sig_second};
      REG_SIG3: prdata = {24'd0, cfg.sig_third};
      default: prdata = 32'd0;
    endcase
  end
endmodule

/* rtl/serial_boot_programming_parser_core.sv */
// Flow: an accepted item is registered in the input register, decoded combinationally
// into up to seven results once the result queue is empty or draining its last entry,
// and the results are registered into the queue, from which the first is offered.
// Throughput: one result per cycle while out_ready is high; an item produces 0..7
// results, and the next item is taken as the last result of the one before is accepted.
// Reset is synchronous, active high; it clears the parser state and loads the register defaults.
module serial_boot_programming_parser_core #(
  parameter int PAGE_BYTES = sbp_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [7:0]  reply_byte,
  output logic [15:0] mem_address,
  output logic [15:0] mem_data,
  output logic [1:0]  fuse_select,
  output logic        last
);
  import sbp_pkg::*;

  localparam logic [15:0] PAGE = 16'(PAGE_BYTES);

  cfg_t cfg;

  sbp_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // input register
  logic        iv;
  logic        iop;
  logic [7:0]  ib;
  logic [15:0] id;

  // result queue
  res_t        q [MAX_RES];
  logic [2:0]  qn;
  logic [2:0]  qi;

  phase_t      ph, ph_next;
  logic [15:0] cur, cur_next;
  logic [7:0]  sel, sel_next;
  logic [15:0] bsz, bsz_next;
  logic [15:0] cnt, cnt_next;
  space_t      sp, sp_next;
  logic [7:0]  held, held_next;
  logic [15:0] pst, pst_next;
  logic        prot, prot_next;

  res_t        r [MAX_RES];
  logic [2:0]  rn;

  logic        q_busy, q_pop_last, take;

  assign q_busy = (qn != 3'd0);
  assign q_pop_last = out_valid & out_ready & (qi == qn - 3'd1);
  // decode stage fires when the queue is empty or draining its last entry
  assign take = iv & (~q_busy | q_pop_last);
  assign in_ready = ~iv | take;

  assign out_valid = q_busy;
  assign kind = q[qi].kind;
  assign reply_byte = q[qi].reply_byte;
  assign mem_address = q[qi].mem_address;
  assign mem_data = q[qi].mem_data;
  assign fuse_select = q[qi].fuse_select;
  assign last = (qi == qn - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
    if (in_ready && in_valid) begin
      iop <= opcode;
      ib <= rx_byte;
      id <= read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qn <= '0;
      qi <= '0;
    end else if (take) begin
      qn <= rn;
      qi <= '0;
    end else if (q_pop_last) begin
      qn <= '0;
      qi <= '0;
    end else if (out_valid && out_ready) begin
      qi <= qi + 3'd1;
    end
    if (take) begin
      for (int k = 0; k < MAX_RES; k++) q[k] <= r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
      cur <= '0;
      sel <= '0;
      bsz <= '0;
      cnt <= '0;
      sp <= SP_NONE;
      held <= '0;
      pst <= '0;
      prot <= 1'b0;
    end else if (take) begin
      ph <= ph_next;
      cur <= cur_next;
      sel <= sel_next;
      bsz <= bsz_next;
      cnt <= cnt_next;
      sp <= sp_next;
      held <= held_next;
      pst <= pst_next;
      prot <= prot_next;
    end
  end

  function automatic logic [15:0] clamp(logic [15:0] s);
    return (s > PAGE) ? PAGE : s;
  endfunction

  always_comb begin
    logic [15:0] w;
    logic [15:0] c1;
    logic [15:0] c2;
    logic        dev_ok;
    ph_next = ph;
    cur_next = cur;
    sel_next = sel;
    bsz_next = bsz;
    cnt_next = cnt;
    sp_next = sp;
    held_next = held;
    pst_next = pst;
    prot_next = prot;
    rn = '0;
    for (int k = 0; k < MAX_RES; k++) r[k] = '0;
    dev_ok = (sel == cfg.device_code);
    w = '0;
    c1 = '0;
    c2 = '0;
    if (!iop) begin
      case (ph)
        PH_IDLE: begin
          case (ib)
            "a": begin r[0] = mk(K_REPLY, "Y", 0, 0, 0); rn = 3'd1; end
            "A": ph_next = PH_ADDR_HI;
            "b": begin
              r[0] = mk(K_REPLY, "Y", 0, 0, 0);
              r[1] = mk(K_REPLY, PAGE[15:8], 0, 0, 0);
              r[2] = mk(K_REPLY, PAGE[7:0], 0, 0, 0);
              rn = 3'd3;
            end
            "B": ph_next = PH_BSZ_HI;
            "g": ph_next = PH_GSZ_HI;
            "e": begin
              if (dev_ok) begin
                r[0] = mk(K_ERASE, 0, 0, 0, 0);
                r[1] = mk(K_REPLY, CH_CR, 0, 0, 0);
                rn = 3'd2;
              end else begin
                r[0] = mk(K_REPLY, CH_CR, 0, 0, 0);
                rn = 3'd1;
              end
            end
            "E": begin
              r[0] = mk(K_REPLY, CH_CR, 0, 0, 0);
              r[1] = mk(K_RESET, 0, 0, 0, 0);
              rn = 3'd2;
            end
            "P", "L": begin r[0] = mk(K_REPLY, CH_CR, 0, 0, 0); rn = 3'd1; end
            "p": begin r[0] = mk(K_REPLY, "S", 0, 0, 0); rn = 3'd1; end
            "F": begin r[0] = mk(K_FUSE, 0, 0, 0, 2'd0); rn = 3'd1; ph_next = PH_WAIT_FUSE; end
            "r": begin r[0] = mk(K_FUSE, 0, 0, 0, 2'd1); rn = 3'd1; ph_next = PH_WAIT_FUSE; end
            "N": begin r[0] = mk(K_FUSE, 0, 0, 0, 2'd2); rn = 3'd1; ph_next = PH_WAIT_FUSE; end
            "Q": begin r[0] = mk(K_FUSE, 0, 0, 0, 2'd3); rn = 3'd1; ph_next = PH_WAIT_FUSE; end
            "t": begin
              r[0] = mk(K_REPLY, cfg.device_code, 0, 0, 0);
              r[1] = mk(K_REPLY, 0, 0, 0, 0);
              rn = 3'd2;
            end
            "x", "y": ph_next = PH_SKIP_ARG;
            "T": ph_next = PH_DEV_ARG;
            "S": begin
              r[0] = mk(K_REPLY, "A", 0, 0, 0);
              r[1] = mk(K_REPLY, "V", 0, 0, 0);
              r[2] = mk(K_REPLY, "R", 0, 0, 0);
              r[3] = mk(K_REPLY, "B", 0, 0, 0);
              r[4] = mk(K_REPLY, "O", 0, 0, 0);
              r[5] = mk(K_REPLY, "O", 0, 0, 0);
              r[6] = mk(K_REPLY, "T", 0, 0, 0);
              rn = 3'd7;
            end
            "V": begin
              r[0] = mk(K_REPLY, "0", 0, 0, 0);
              r[1] = mk(K_REPLY, "1", 0, 0, 0);
              rn = 3'd2;
            end
            "s": begin
              r[0] = mk(K_REPLY, cfg.sig_third, 0, 0, 0);
              r[1] = mk(K_REPLY, cfg.sig_second, 0, 0, 0);
              r[2] = mk(K_REPLY, cfg.sig_first, 0, 0, 0);
              rn = 3'd3;
            end
            CH_ESC: ;
            default: begin r[0] = mk(K_REPLY, "?", 0, 0, 0); rn = 3'd1; end
          endcase
        end
        PH_ADDR_HI: begin cur_next = {ib, 8'd0}; ph_next = PH_ADDR_LO; end
        PH_ADDR_LO: begin
          cur_next = cur | {8'd0, ib};
          r[0] = mk(K_REPLY, CH_CR, 0, 0, 0);
          rn = 3'd1;
          ph_next = PH_IDLE;
        end
        PH_BSZ_HI: begin bsz_next = {ib, 8'd0}; ph_next = PH_BSZ_LO; end
        PH_BSZ_LO: begin bsz_next = clamp(bsz | {8'd0, ib}); ph_next = PH_BTYPE; end
        PH_BTYPE: begin
          cnt_next = '0;
          held_next = '0;
          if (!dev_ok) sp_next = SP_BADDEV;
          else if (ib == "F") begin sp_next = SP_FLASH; pst_next = cur; end
          else if (ib == "E") sp_next = SP_EE;
          else sp_next = SP_NONE;
          if (bsz == 16'd0) begin
            // empty block: reply at once, never a flash write
            r[0] = mk(K_REPLY, (sp_next == SP_BADDEV) ? 8'd0 : CH_CR, 0, 0, 0);
            rn = 3'd1;
            ph_next = PH_IDLE;
          end else begin
            ph_next = PH_BDATA;
          end
        end
        PH_BDATA: begin
          c1 = cnt + 16'd1;
          cnt_next = c1;
          if (sp == SP_FLASH) begin
            if (!cnt[0]) held_next = ib;
            else begin
              r[rn] = mk(K_FILL, 0, cur, {ib, held}, 0);
              rn = rn + 3'd1;
              cur_next = cur + 16'd1;
            end
          end else if (sp == SP_EE) begin
            r[rn] = mk(K_EEWR, 0, cur, {8'd0, ib}, 0);
            rn = rn + 3'd1;
            cur_next = cur + 16'd1;
          end
          if (c1 >= bsz) begin
            if (sp == SP_FLASH) begin
              if (bsz[0]) begin
                r[rn] = mk(K_FILL, 0, cur_next, {8'hff, held_next}, 0);
                rn = rn + 3'd1;
                cur_next = cur_next + 16'd1;
              end
              r[rn] = mk(K_COMMIT, 0, pst, 0, 0);
              rn = rn + 3'd1;
            end
            r[rn] = mk(K_REPLY, (sp == SP_BADDEV) ? 8'd0 : CH_CR, 0, 0, 0);
            rn = rn + 3'd1;
            ph_next = PH_IDLE;
          end
        end
        PH_GSZ_HI: begin bsz_next = {ib, 8'd0}; ph_next = PH_GSZ_LO; end
        PH_GSZ_LO: begin bsz_next = clamp(bsz | {8'd0, ib}); ph_next = PH_GTYPE; end
        PH_GTYPE: begin
          cnt_next = '0;
          ph_next = PH_IDLE;
          if (bsz != 16'd0) begin
            if (ib == "F") begin
              sp_next = SP_FLASH;
              prot_next = cfg.read_protect & ({1'b0, cur, 1'b0} >= cfg.app_end_bytes);
              r[0] = mk(K_FLRD, 0, cur, 0, 0);
              rn = 3'd1;
              ph_next = PH_WAIT_FLASH;
            end else if (ib == "E") begin
              sp_next = SP_EE;
              r[0] = mk(K_EERD, 0, cur, 0, 0);
              rn = 3'd1;
              ph_next = PH_WAIT_EE;
            end
          end
        end
        PH_SKIP_ARG: begin
          r[0] = mk(K_REPLY, CH_CR, 0, 0, 0);
          rn = 3'd1;
          ph_next = PH_IDLE;
        end
        PH_DEV_ARG: begin
          sel_next = ib;
          r[0] = mk(K_REPLY, CH_CR, 0, 0, 0);
          rn = 3'd1;
          ph_next = PH_IDLE;
        end
        default: ;
      endcase
    end else begin
      case (ph)
        PH_WAIT_FLASH: begin
          w = prot ? 16'hffff : id;
          r[0] = mk(K_REPLY, w[7:0], 0, 0, 0);
          rn = 3'd1;
          c1 = cnt + 16'd1;
          c2 = c1;
          if (c1 < bsz) begin
            r[1] = mk(K_REPLY, w[15:8], 0, 0, 0);
            rn = 3'd2;
            c2 = c1 + 16'd1;
          end
          cnt_next = c2;
          cur_next = cur + 16'd1;
          if (c2 < bsz) begin
            prot_next = cfg.read_protect & ({1'b0, cur_next, 1'b0} >= cfg.app_end_bytes);
            r[rn] = mk(K_FLRD, 0, cur_next, 0, 0);
            rn = rn + 3'd1;
          end else begin
            prot_next = 1'b0;
            ph_next = PH_IDLE;
          end
        end
        PH_WAIT_EE: begin
          r[0] = mk(K_REPLY, id[7:0], 0, 0, 0);
          rn = 3'd1;
          cur_next = cur + 16'd1;
          c1 = cnt + 16'd1;
          cnt_next = c1;
          if (c1 < bsz) begin
            r[1] = mk(K_EERD, 0, cur_next, 0, 0);
            rn = 3'd2;
          end else begin
            ph_next = PH_IDLE;
          end
        end
        PH_WAIT_FUSE: begin
          r[0] = mk(K_REPLY, id[7:0], 0, 0, 0);
          rn = 3'd1;
          ph_next = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_qi_range: assert property (@(posedge clk) disable iff (rst)
    q_busy |-> (qi < qn)) else $error("result index beyond count");
  a_no_take_mid: assert property (@(posedge clk) disable iff (rst)
    (q_busy && !q_pop_last) |-> !take) else $error("decode while results pending");
  // the high size byte is held unclamped until the low byte arrives
  a_bsz_clamp: assert property (@(posedge clk) disable iff (rst)
    (ph != PH_BSZ_LO && ph != PH_GSZ_LO) |-> (bsz <= PAGE))
    else $error("block size above page");
  a_prot_idle: assert property (@(posedge clk) disable iff (rst)
    (ph != PH_WAIT_FLASH) |-> !prot) else $error("protect flag outside flash read");
`endif
endmodule
